FILE: rtl/ccg_pkg.sv
// Shared types and constants of the charset combination generator.
package ccg_pkg;

    localparam int C_IDX_W     = 63;   // index and count width
    localparam int C_CFG_W     = 64;   // widest configuration register
    localparam int C_CFG_IDX_W = 3;    // configuration register index width
    localparam int C_NUM_WORDS = 6;    // charset words
    localparam int C_SIZE_W    = 6;    // charset_size register width
    localparam int C_LEN_W     = 5;    // comb_length register width
    localparam int C_DIGIT_W   = 6;    // one digit indexes the set
    localparam int C_CHAR_W    = 8;
    localparam int C_POS_W     = 4;
    localparam int C_OUT_W     = 16;   // out_char + char_position, byte padded
    localparam int C_IN_W      = 64;   // index, byte padded

    localparam logic [C_SIZE_W-1:0] C_MAX_CHARS = 6'd48;
    localparam logic [C_IDX_W-1:0]  C_SAT_MAX   = {C_IDX_W{1'b1}};
    localparam logic [5:0]          C_DIV_LAST  = 6'(C_IDX_W - 1);

    // request kinds (tuser on the slave side)
    localparam logic C_CMD_NEXT = 1'b0;
    localparam logic C_CMD_JUMP = 1'b1;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SIZE = 3'd6;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_LEN  = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic tot_init;
        logic tot_step;
        logic jump_take;
        logic div_step;
        logic emit_start;
        logic out_char;
        logic out_status;
        logic status_ok;
        logic inc_write;
        logic cur_inc;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic cfg_write;
        logic in_valid;
        logic tot_done;
        logic cmd_jump;
        logic idx_ok;
        logic cur_ok;
        logic div_digit_done;
        logic pos_zero;
        logic pos_last;
        logic out_free;
        logic inc_carry;
    } t_dp_sts;

endpackage

FILE: rtl/ccg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ccg_ctrl.sv
// Sequencing state machine of the charset combination generator.
module ccg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccg_pkg::t_dp_sts   i_sts,
    output ccg_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_TINIT     = 11'b000_0000_0001,
        S_TOT       = 11'b000_0000_0010,
        S_IDLE      = 11'b000_0000_0100,
        S_DECODE    = 11'b000_0000_1000,
        S_DIV       = 11'b000_0001_0000,
        S_RESP_OK   = 11'b000_0010_0000,
        S_RESP_FAIL = 11'b000_0100_0000,
        S_RADDR     = 11'b000_1000_0000,
        S_RDATA     = 11'b001_0000_0000,
        S_IWAIT     = 11'b010_0000_0000,
        S_IWR       = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TINIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_TINIT: begin
                o_cmd.tot_init = 1'b1;
                n_state        = S_TOT;
            end
            S_TOT: begin
                if (i_sts.tot_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.tot_step = 1'b1;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.cmd_jump) begin
                    if (i_sts.idx_ok) begin
                        o_cmd.jump_take = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_RESP_FAIL;
                    end
                end else if (i_sts.cur_ok) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_RADDR;
                end else begin
                    n_state = S_RESP_FAIL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_digit_done && i_sts.pos_zero) begin
                    n_state = S_RESP_OK;
                end
            end
            S_RESP_OK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_status = 1'b1;
                    o_cmd.status_ok  = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RESP_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_status = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RADDR: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                if (i_sts.out_free) begin
                    o_cmd.out_char = 1'b1;
                    if (i_sts.pos_last) begin
                        o_cmd.cur_inc = 1'b1;
                        n_state       = S_IWAIT;
                    end else begin
                        n_state = S_RADDR;
                    end
                end
            end
            S_IWAIT: begin
                n_state = S_IWR;
            end
            S_IWR: begin
                o_cmd.inc_write = 1'b1;
                if (i_sts.inc_carry && !i_sts.pos_zero) begin
                    n_state = S_IWAIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_TINIT;
            end
        endcase
        // a configuration write restarts the enumeration
        if (i_sts.cfg_write) begin
            n_state = S_TINIT;
        end
    end

endmodule

FILE: rtl/ccg_datapath.sv
// Datapath: config registers, total count, index, digit store, divider, output register.
module ccg_datapath #(
    parameter int MAX_LENGTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ccg_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ccg_pkg::C_CFG_W-1:0]        i_cfg_wdata,
    input  logic                               s_tvalid,
    input  logic [ccg_pkg::C_IN_W-1:0]         s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ccg_pkg::C_OUT_W-1:0]        m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  ccg_pkg::t_ctrl_cmd                 i_cmd,
    output ccg_pkg::t_dp_sts                   o_sts
);

    localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CW = $clog2(MAX_LENGTH + 1);

    // configuration
    logic [ccg_pkg::C_CFG_W-1:0]    r_cs [ccg_pkg::C_NUM_WORDS];
    logic [ccg_pkg::C_SIZE_W-1:0]   r_size;
    logic [ccg_pkg::C_LEN_W-1:0]    r_len;

    // enumeration state
    logic [ccg_pkg::C_IDX_W-1:0]    r_cur;
    logic [ccg_pkg::C_IDX_W-1:0]    r_tot;
    logic [CW-1:0]                  r_tot_cnt;
    logic                           r_tot_sat;
    logic                           r_cmd;
    logic [ccg_pkg::C_IDX_W-1:0]    r_idx;
    logic [ccg_pkg::C_IDX_W-1:0]    r_div;
    logic [ccg_pkg::C_DIGIT_W-1:0]  r_rem;
    logic [5:0]                     r_div_cnt;
    logic [LW-1:0]                  r_pos;
    logic [MAX_LENGTH-1:0]          r_valid;

    // output register
    logic                           r_out_valid;
    logic [ccg_pkg::C_CHAR_W-1:0]   r_out_char;
    logic [ccg_pkg::C_POS_W-1:0]    r_out_pos;
    logic                           r_out_ok;
    logic                           r_out_last;

    logic [ccg_pkg::C_SIZE_W-1:0]   w_size;
    logic [6:0]                     w_len_wide;
    logic [CW-1:0]                  w_len;
    logic [LW-1:0]                  w_lastpos;
    logic [ccg_pkg::C_IDX_W+ccg_pkg::C_SIZE_W-1:0] w_prod;
    logic                           w_prod_ovf;
    logic [ccg_pkg::C_DIGIT_W:0]    w_r2;
    logic                           w_ge;
    logic [ccg_pkg::C_DIGIT_W-1:0]  w_rnew;
    logic                           w_div_last;
    logic [ccg_pkg::C_DIGIT_W-1:0]  w_rdata;
    logic [ccg_pkg::C_DIGIT_W-1:0]  w_digit;
    logic [ccg_pkg::C_DIGIT_W:0]    w_digit_inc;
    logic                           w_carry;
    logic [2:0]                     w_word;
    logic [ccg_pkg::C_CHAR_W-1:0]   w_char;
    logic                           w_ram_we;
    logic [ccg_pkg::C_DIGIT_W-1:0]  w_ram_wdata;
    logic                           w_accept;

    // effective size and length
    always_comb begin
        w_size = (r_size > ccg_pkg::C_MAX_CHARS) ? ccg_pkg::C_MAX_CHARS : r_size;
        if (r_len == '0) begin
            w_len_wide = 7'd1;
        end else if (7'(r_len) > 7'(MAX_LENGTH)) begin
            w_len_wide = 7'(MAX_LENGTH);
        end else begin
            w_len_wide = 7'(r_len);
        end
    end
    assign w_len     = w_len_wide[CW-1:0];
    assign w_lastpos = LW'(w_len_wide - 7'd1);

    // one power step per cycle, saturating
    assign w_prod     = r_tot * w_size;
    assign w_prod_ovf = (w_size != '0) &&
                        (w_prod > {{ccg_pkg::C_SIZE_W{1'b0}}, ccg_pkg::C_SAT_MAX});

    // restoring division, one quotient bit per cycle
    assign w_r2       = {r_rem, r_div[ccg_pkg::C_IDX_W-1]};
    assign w_ge       = (w_r2 >= {1'b0, w_size});
    assign w_rnew     = w_ge ? ccg_pkg::C_DIGIT_W'(w_r2 - {1'b0, w_size})
                             : w_r2[ccg_pkg::C_DIGIT_W-1:0];
    assign w_div_last = (r_div_cnt == ccg_pkg::C_DIV_LAST);

    // digit store read; unwritten entries read as zero
    assign w_digit     = r_valid[r_pos] ? w_rdata : '0;
    assign w_digit_inc = {1'b0, w_digit} + 7'd1;
    assign w_carry     = (w_digit_inc == {1'b0, w_size});

    // character lookup, word wraps modulo the word count
    assign w_word = (w_digit[5:3] >= 3'd6) ? (w_digit[5:3] - 3'd6) : w_digit[5:3];
    assign w_char = r_cs[w_word][{w_digit[2:0], 3'b000} +: ccg_pkg::C_CHAR_W];

    assign w_ram_we    = (i_cmd.div_step && w_div_last) || i_cmd.inc_write;
    assign w_ram_wdata = i_cmd.inc_write ? (w_carry ? '0 : w_digit_inc[ccg_pkg::C_DIGIT_W-1:0])
                                         : w_rnew;

    assign w_accept = i_cmd.in_ready && s_tvalid;

    ccg_ram #(
        .WIDTH (ccg_pkg::C_DIGIT_W),
        .DEPTH (MAX_LENGTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ccg_pkg::C_NUM_WORDS; i++) begin
                r_cs[i] <= '0;
            end
            r_size  <= ccg_pkg::C_SIZE_W'(1);
            r_len   <= ccg_pkg::C_LEN_W'(1);
            r_cur   <= '0;
            r_valid <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ccg_pkg::C_REG_SIZE: r_size <= i_cfg_wdata[ccg_pkg::C_SIZE_W-1:0];
                ccg_pkg::C_REG_LEN:  r_len  <= i_cfg_wdata[ccg_pkg::C_LEN_W-1:0];
                default:             r_cs[i_cfg_index] <= i_cfg_wdata;
            endcase
            r_cur   <= '0;
            r_valid <= '0;
        end else begin
            if (i_cmd.jump_take) begin
                r_cur <= r_idx;
            end else if (i_cmd.cur_inc) begin
                r_cur <= r_cur + 1'b1;
            end
            if (w_ram_we) begin
                r_valid[r_pos] <= 1'b1;
            end
        end
    end

    // total count, request latch, divider and position
    always_ff @(posedge i_clk) begin
        if (i_cmd.tot_init) begin
            r_tot     <= ccg_pkg::C_IDX_W'(1);
            r_tot_cnt <= '0;
            r_tot_sat <= 1'b0;
        end else if (i_cmd.tot_step) begin
            r_tot_cnt <= r_tot_cnt + 1'b1;
            if (w_prod_ovf) begin
                r_tot     <= ccg_pkg::C_SAT_MAX;
                r_tot_sat <= 1'b1;
            end else begin
                r_tot <= w_prod[ccg_pkg::C_IDX_W-1:0];
            end
        end

        if (w_accept) begin
            r_cmd <= s_tuser;
            r_idx <= s_tdata[ccg_pkg::C_IDX_W-1:0];
        end

        if (i_cmd.jump_take) begin
            r_div     <= r_idx;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_pos     <= w_lastpos;
        end else if (i_cmd.div_step) begin
            r_div <= {r_div[ccg_pkg::C_IDX_W-2:0], w_ge};
            if (w_div_last) begin
                r_rem     <= '0;
                r_div_cnt <= '0;
                if (r_pos != '0) begin
                    r_pos <= r_pos - 1'b1;
                end
            end else begin
                r_rem     <= w_rnew;
                r_div_cnt <= r_div_cnt + 1'b1;
            end
        end else if (i_cmd.emit_start) begin
            r_pos <= '0;
        end else if (i_cmd.out_char) begin
            if (r_pos != w_lastpos) begin
                r_pos <= r_pos + 1'b1;
            end
        end else if (i_cmd.inc_write) begin
            if (w_carry && (r_pos != '0)) begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_char || i_cmd.out_status) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_char) begin
            r_out_char <= w_char;
            r_out_pos  <= ccg_pkg::C_POS_W'(r_pos);
            r_out_ok   <= 1'b1;
            r_out_last <= (r_pos == w_lastpos);
        end else if (i_cmd.out_status) begin
            r_out_char <= '0;
            r_out_pos  <= '0;
            r_out_ok   <= i_cmd.status_ok;
            r_out_last <= 1'b1;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(ccg_pkg::C_OUT_W - ccg_pkg::C_CHAR_W - ccg_pkg::C_POS_W){1'b0}},
                       r_out_pos, r_out_char};
    assign m_tuser  = r_out_ok;
    assign m_tlast  = r_out_last;

    always_comb begin
        o_sts                = '0;
        o_sts.cfg_write      = i_cfg_we;
        o_sts.in_valid       = s_tvalid;
        o_sts.tot_done       = r_tot_sat || (r_tot_cnt == w_len);
        o_sts.cmd_jump       = (r_cmd == ccg_pkg::C_CMD_JUMP);
        o_sts.idx_ok         = (r_idx < r_tot);
        o_sts.cur_ok         = (r_cur < r_tot);
        o_sts.div_digit_done = w_div_last;
        o_sts.pos_zero       = (r_pos == '0);
        o_sts.pos_last       = (r_pos == w_lastpos);
        o_sts.out_free       = !r_out_valid || m_tready;
        o_sts.inc_carry      = w_carry;
    end

endmodule

FILE: rtl/charset_combination_generator.sv
// Top level of the charset combination generator: controller plus datapath.
//
// Use:
//   Configure through i_cfg_we/i_cfg_index/i_cfg_wdata (charset words 0..5,
//   size, length). Every write restarts the enumeration at index zero and
//   recomputes the string count, size ** length saturated at 2^63-1; no
//   request is taken while the count is being computed.
//   Slave stream: s_tuser selects next (0) or jump (1), s_tdata carries the
//   jump index. A next request returns one result per character, leftmost
//   first, tlast on the final one, then advances the index. An exhausted next
//   and every jump return a single status result (tuser = ok, tlast = 1).
//   Sequence: a next is decoded, then each character passes through the
//   registered digit store read, then the increment ripples through 1 to
//   length digits. A jump runs the restoring divider for each digit.
//   One request is worked on at a time; the next request is taken while the
//   last result still sits in the output register.
//   A stalled receiver (m_tready low) freezes the sequencer at the output
//   register; nothing is dropped. Reset restores the default configuration
//   (size 1, length 1) and runs the count computation before the first request.
module charset_combination_generator #(
    parameter int MAX_LENGTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ccg_pkg::C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccg_pkg::C_CFG_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ccg_pkg::C_IN_W-1:0]      s_tdata,   // [62:0] index, [63] zero
    input  logic                            s_tuser,   // [0] command
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ccg_pkg::C_OUT_W-1:0]     m_tdata,   // [7:0] out_char, [11:8] char_position
    output logic                            m_tuser,   // [0] ok
    output logic                            m_tlast
);

    ccg_pkg::t_ctrl_cmd w_cmd;
    ccg_pkg::t_dp_sts   w_sts;

    ccg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ccg_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    // request accepted only in idle
    assign s_tready = w_cmd.in_ready;

endmodule

FILE: rtl/ccg_checker.sv
// Port-level assertions for the charset combination generator, bound to the top level.
module ccg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [ccg_pkg::C_CFG_IDX_W-1:0] i_cfg_index,
    input logic [ccg_pkg::C_CFG_W-1:0]     i_cfg_wdata,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ccg_pkg::C_IN_W-1:0]      s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ccg_pkg::C_OUT_W-1:0]     m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // failed requests give one zeroed result
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("failure result not a single zeroed item");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind charset_combination_generator ccg_checker u_ccg_checker (.*);
